>>> rtl/lpc2cep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpc2cep_pkg
// shared types, sizes and the reciprocal table of the lpc-to-cepstrum block
// ----------------------------------------------------------------------------
package lpc2cep_pkg;

	localparam int MAX_ORDER = 32;
	localparam int ADDR_W    = $clog2(MAX_ORDER);
	localparam int IDX_W     = 6;
	localparam int COEF_W    = 32;
	localparam int ACC_W     = 64;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// one input beat
	typedef struct packed {
		logic signed [COEF_W-1:0] lpc_coef;
		logic                     frame_end;
	} in_item_t;

	// one result beat
	typedef struct packed {
		logic signed [COEF_W-1:0] cep_coef;
		idx_t                     cep_index;
		logic                     last_of_run;
		logic                     saturated;
	} out_item_t;

	// sequencer to datapath
	typedef struct packed {
		logic issue;
		idx_t k;
		logic acc_clr;
		logic div_lo;
		logic div_hi;
		idx_t idx;
	} mac_ctl_t;

	localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;

	// floor((2^32 + floor(i/2)) / i), index one reads as zero (accumulator is zero there)
	function automatic logic [31:0] recip(input idx_t i);
		logic [31:0] r;
		case (i)
			6'd2:    r = 32'((RECIP_NUM + 64'd1) / 64'd2);
			6'd3:    r = 32'((RECIP_NUM + 64'd1) / 64'd3);
			6'd4:    r = 32'((RECIP_NUM + 64'd2) / 64'd4);
			6'd5:    r = 32'((RECIP_NUM + 64'd2) / 64'd5);
			6'd6:    r = 32'((RECIP_NUM + 64'd3) / 64'd6);
			6'd7:    r = 32'((RECIP_NUM + 64'd3) / 64'd7);
			6'd8:    r = 32'((RECIP_NUM + 64'd4) / 64'd8);
			6'd9:    r = 32'((RECIP_NUM + 64'd4) / 64'd9);
			6'd10:   r = 32'((RECIP_NUM + 64'd5) / 64'd10);
			6'd11:   r = 32'((RECIP_NUM + 64'd5) / 64'd11);
			6'd12:   r = 32'((RECIP_NUM + 64'd6) / 64'd12);
			6'd13:   r = 32'((RECIP_NUM + 64'd6) / 64'd13);
			6'd14:   r = 32'((RECIP_NUM + 64'd7) / 64'd14);
			6'd15:   r = 32'((RECIP_NUM + 64'd7) / 64'd15);
			6'd16:   r = 32'((RECIP_NUM + 64'd8) / 64'd16);
			6'd17:   r = 32'((RECIP_NUM + 64'd8) / 64'd17);
			6'd18:   r = 32'((RECIP_NUM + 64'd9) / 64'd18);
			6'd19:   r = 32'((RECIP_NUM + 64'd9) / 64'd19);
			6'd20:   r = 32'((RECIP_NUM + 64'd10) / 64'd20);
			6'd21:   r = 32'((RECIP_NUM + 64'd10) / 64'd21);
			6'd22:   r = 32'((RECIP_NUM + 64'd11) / 64'd22);
			6'd23:   r = 32'((RECIP_NUM + 64'd11) / 64'd23);
			6'd24:   r = 32'((RECIP_NUM + 64'd12) / 64'd24);
			6'd25:   r = 32'((RECIP_NUM + 64'd12) / 64'd25);
			6'd26:   r = 32'((RECIP_NUM + 64'd13) / 64'd26);
			6'd27:   r = 32'((RECIP_NUM + 64'd13) / 64'd27);
			6'd28:   r = 32'((RECIP_NUM + 64'd14) / 64'd28);
			6'd29:   r = 32'((RECIP_NUM + 64'd14) / 64'd29);
			6'd30:   r = 32'((RECIP_NUM + 64'd15) / 64'd30);
			6'd31:   r = 32'((RECIP_NUM + 64'd15) / 64'd31);
			6'd32:   r = 32'((RECIP_NUM + 64'd16) / 64'd32);
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lpc2cep_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpc2cep_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lpc2cep_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/lpc2cep_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpc2cep_mac
// term pipeline, 64-bit accumulator and reciprocal divide with saturation
// ----------------------------------------------------------------------------
module lpc2cep_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lpc2cep_pkg::mac_ctl_t              ctl,
	input  wire logic signed [lpc2cep_pkg::COEF_W-1:0] lpc_rdata,
	input  wire logic signed [lpc2cep_pkg::COEF_W-1:0] cep_rdata,
	output logic                                    pipe_busy,
	output logic signed [lpc2cep_pkg::COEF_W-1:0]   res_coef,
	output logic                                    res_sat
);
	import lpc2cep_pkg::*;

	logic                    v_s1, v_s2;
	idx_t                    k_s1, k_s2;
	logic signed [63:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [47:0]      term;
	logic signed [54:0]      term_k;
	logic                    neg;
	logic [ACC_W-1:0]        mag;
	logic [31:0]             r;
	logic [63:0]             lo_q, hi_q;
	logic                    neg_q;
	logic [63:0]             quot;
	logic signed [65:0]      quot_s, val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	// floor shift to q16.16, then weight by k
	assign term   = prod_s2[63:16];
	assign term_k = term * $signed({1'b0, k_s2});

	assign neg = acc_q[ACC_W-1];
	assign mag = neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign r   = recip(ctl.idx);

	always_ff @(posedge clk) begin
		k_s1    <= ctl.k;
		k_s2    <= k_s1;
		prod_s2 <= lpc_rdata * cep_rdata;
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W-55){term_k[54]}}, term_k};
		end
		if (ctl.div_lo) begin
			lo_q  <= {32'd0, mag[31:0]} * {32'd0, r};
			neg_q <= neg;
		end
		if (ctl.div_hi) begin
			hi_q <= {32'd0, mag[63:32]} * {32'd0, r};
		end
	end

	assign pipe_busy = v_s1 | v_s2;

	// lpc_rdata holds a[i] while the result is formed
	always_comb begin
		quot   = hi_q + {32'd0, lo_q[63:32]};
		quot_s = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
		val    = -{{34{lpc_rdata[COEF_W-1]}}, lpc_rdata} - quot_s;
		if (val > 66'sh0_0000_0000_7FFF_FFFF) begin
			res_coef = 32'sh7FFF_FFFF;
			res_sat  = 1'b1;
		end else if (val < -66'sh0_0000_0000_8000_0000) begin
			res_coef = -32'sh8000_0000;
			res_sat  = 1'b1;
		end else begin
			res_coef = val[31:0];
			res_sat  = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lpc_to_cepstrum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_to_cepstrum
// loads a frame of q16.16 predictor coefficients and emits the cepstrum
// c[1..n] by the standard recursion
// ----------------------------------------------------------------------------
// loading: one coefficient per cycle, busy stays low while a frame fills
// run: coefficient i above one issues its i-1 product terms in turn through the single
//   multiplier and the one read port of each ram, waits for the pipeline to drain, runs
//   the low and high reciprocal divide steps, then emits; coefficient one has no terms
// each result shows in the cycle after it is formed, for exactly one cycle, never stalled
// reset: loaded count cleared, out_order back to 32; ram contents are not cleared
// ----------------------------------------------------------------------------
module lpc_to_cepstrum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire lpc2cep_pkg::in_item_t item,
	output logic                       result_valid,
	output lpc2cep_pkg::out_item_t     result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [5:0]            cfg_data
);
	import lpc2cep_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TERM   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DIV_LO = 3'd3;
	localparam logic [2:0] S_DIV_HI = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]  state_q;
	idx_t        loaded_q;   // coefficients held for the current frame
	idx_t        i_q;        // coefficient under work
	idx_t        n_q;        // last index of the run
	idx_t        k_q;        // product term being issued
	logic [5:0]  out_order_q;

	logic        accept;
	logic        room;
	idx_t        new_cnt;
	idx_t        n_new;

	mac_ctl_t    ctl;
	logic        pipe_busy;
	logic signed [COEF_W-1:0] res_coef;
	logic        res_sat;

	logic        lpc_we;
	addr_t       lpc_raddr;
	addr_t       cep_raddr;
	logic [COEF_W-1:0] lpc_rdata, cep_rdata;

	out_item_t   result_q;
	logic        result_valid_q;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = ~busy;
	assign accept    = start & ~busy;

	// coefficients past the store depth are dropped, frame_end still counts
	assign room    = (loaded_q < IDX_W'(MAX_ORDER));
	assign new_cnt = room ? loaded_q + 6'd1 : loaded_q;
	assign n_new   = (out_order_q < new_cnt) ? out_order_q : new_cnt;
	assign lpc_we  = accept & room;

	// term k reads a[i-k] and c[k]; outside the term loop port a reads a[i]
	always_comb begin
		if (state_q == S_TERM) begin
			lpc_raddr = ADDR_W'(i_q - k_q - 6'd1);
		end else begin
			lpc_raddr = ADDR_W'(i_q - 6'd1);
		end
		cep_raddr = ADDR_W'(k_q - 6'd1);
	end

	always_comb begin
		ctl.issue   = (state_q == S_TERM);
		ctl.k       = k_q;
		ctl.acc_clr = (accept & item.frame_end & (n_new != '0))
			| ((state_q == S_EMIT) & (i_q != n_q));
		ctl.div_lo  = (state_q == S_DIV_LO);
		ctl.div_hi  = (state_q == S_DIV_HI);
		ctl.idx     = i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			loaded_q       <= '0;
			i_q            <= '0;
			n_q            <= '0;
			k_q            <= '0;
			out_order_q    <= 6'd32;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == S_EMIT);
			if (cfg_valid & cfg_ready) begin
				out_order_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.frame_end) begin
							loaded_q <= '0;
							n_q      <= n_new;
							i_q      <= 6'd1;
							k_q      <= 6'd1;
							// first coefficient has no product terms
							if (n_new != '0) begin
								state_q <= S_DRAIN;
							end
						end else begin
							loaded_q <= new_cnt;
						end
					end
				end
				S_TERM: begin
					if (k_q == i_q - 6'd1) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 6'd1;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_DIV_LO;
					end
				end
				S_DIV_LO: state_q <= S_DIV_HI;
				S_DIV_HI: state_q <= S_EMIT;
				S_EMIT: begin
					if (i_q == n_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 6'd1;
						k_q     <= 6'd1;
						state_q <= S_TERM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			result_q.cep_coef    <= res_coef;
			result_q.cep_index   <= i_q;
			result_q.last_of_run <= (i_q == n_q);
			result_q.saturated   <= res_sat;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	lpc2cep_ram #(
		.DEPTH(MAX_ORDER),
		.WIDTH(COEF_W)
	) u_lpc_ram (
		.clk   (clk),
		.we    (lpc_we),
		.waddr (ADDR_W'(loaded_q)),
		.wdata (item.lpc_coef),
		.raddr (lpc_raddr),
		.rdata (lpc_rdata)
	);

	// saturated c[i] goes back for later terms
	lpc2cep_ram #(
		.DEPTH(MAX_ORDER),
		.WIDTH(COEF_W)
	) u_cep_ram (
		.clk   (clk),
		.we    (state_q == S_EMIT),
		.waddr (ADDR_W'(i_q - 6'd1)),
		.wdata (res_coef),
		.raddr (cep_raddr),
		.rdata (cep_rdata)
	);

	lpc2cep_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.lpc_rdata ($signed(lpc_rdata)),
		.cep_rdata ($signed(cep_rdata)),
		.pipe_busy (pipe_busy),
		.res_coef  (res_coef),
		.res_sat   (res_sat)
	);

endmodule
`default_nettype wire
